// File: design/pcbe_pkg.sv
// ----------------------------------------------------------------------------
// pcbe_pkg
// Shared types and constants for the POCSAG codeword batch encoder.
// ----------------------------------------------------------------------------
package pcbe_pkg;

  localparam int unsigned BatchWords  = 16;
  localparam int unsigned MaxPreamble = 32;

  localparam int unsigned MsgBits   = 21;
  localparam int unsigned CheckBits = 10;
  localparam int unsigned WordBits  = 32;

  localparam logic [31:0] SyncWord     = 32'h7CD2_15D8;
  localparam logic [31:0] IdleWord     = 32'h7A89_C197;
  localparam logic [31:0] PreambleWord = 32'hAAAA_AAAA;
  // x^10+x^9+x^8+x^6+x^5+x^3+1, aligned to the top of the remainder register
  localparam logic [31:0] BchGen       = 32'hED20_0000;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_MESSAGE = 2'd1,
    CMD_END     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PREAMBLE = 3'd0,
    KIND_SYNC     = 3'd1,
    KIND_IDLE     = 3'd2,
    KIND_ADDRESS  = 3'd3,
    KIND_MESSAGE  = 3'd4
  } word_kind_e;

  typedef struct packed {
    logic                 start;
    logic [MsgBits-1:0]   msg;
  } bch_req_t;

endpackage

// File: design/pcbe_bch.sv
// ----------------------------------------------------------------------------
// pcbe_bch
// Bit-serial BCH(31,21) encoder with even parity; one division step a cycle.
// ----------------------------------------------------------------------------
module pcbe_bch (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pcbe_pkg::bch_req_t                    req_i,
  output logic                                  done_o,
  output logic [pcbe_pkg::WordBits-1:0]         codeword_o
);
  import pcbe_pkg::*;

  logic [WordBits-1:0]  rem_q, rem_d;
  logic [MsgBits-1:0]   msg_q;
  logic [4:0]           cnt_q;
  logic                 busy_q;
  logic [CheckBits-1:0] check;

  always_comb begin
    rem_d = rem_q[WordBits-1] ? (rem_q ^ BchGen) : rem_q;
    rem_d = {rem_d[WordBits-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(MsgBits - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      msg_q <= req_i.msg;
      rem_q <= {req_i.msg, {(WordBits-MsgBits){1'b0}}};
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign check      = rem_q[WordBits-1 -: CheckBits];
  assign done_o     = !busy_q;
  assign codeword_o = {msg_q, check, ^{msg_q, check}};

endmodule

// File: design/pocsag_codeword_batch_encoder_unit.sv
// ----------------------------------------------------------------------------
// pocsag_codeword_batch_encoder_unit
// POCSAG transmit codeword stream builder (preamble, sync, idle, address and
// message codewords in 16-word batches).
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the command (start, message, end); tdata the
//   address, function bits and payload. One transaction per command.
//   Master stream: one codeword per transaction, tuser is the word kind,
//   tlast marks the final word caused by a command.
//   Config channel: preamble word count, always ready; write only when idle.
// Timing:
//   A command is taken only while the sequencer is idle. Filler words
//   (preamble, sync, idle) leave at one per cycle while the receiver keeps
//   up. Address and message codewords come from a bit-serial BCH unit that
//   starts when the command is taken; the word is registered once the unit
//   is done, and the sequencer then returns to idle for the next command.
//   A start command sends up to 48 words (preamble, sync, idles, address),
//   an end command its padding words.
//   A one-word output register lets the next command in while the last word
//   still waits; a stalled receiver simply holds the sequencer.
// Reset: batch position 0, preamble count 18, output empty.
// ----------------------------------------------------------------------------
module pocsag_codeword_batch_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: preamble_words
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [20:0] address, [22:21] function_bits, [42:23] payload, [47:43] zero
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] codeword
  output logic [31:0] m_axis_tdata_o,
  // [2:0] word_kind
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import pcbe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SYNC,
    ST_FILL,
    ST_CODE,
    ST_PAD
  } state_e;

  state_e      state_q;
  logic [5:0]  pre_q;
  logic [4:0]  pos_q;
  logic [5:0]  cnt_q;
  logic [2:0]  frame_q;
  cmd_e        cmd_q;
  word_kind_e  code_kind_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  word_kind_e  out_kind_q;
  logic        out_last_q;

  bch_req_t    bch_req;
  logic        bch_done;
  logic [31:0] bch_word;

  logic        in_fire;
  logic        can_emit;
  logic        word_emit;
  cmd_e        in_cmd;
  logic [20:0] in_address;
  logic [1:0]  in_fbits;
  logic [19:0] in_payload;
  logic [5:0]  pre_sat;

  assign in_cmd     = cmd_e'(s_axis_tuser_i);
  assign in_address = s_axis_tdata_i[20:0];
  assign in_fbits   = s_axis_tdata_i[22:21];
  assign in_payload = s_axis_tdata_i[42:23];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign can_emit        = !out_valid_q || m_axis_tready_i;
  assign word_emit       = can_emit && ((state_q == ST_PRE) || (state_q == ST_SYNC) ||
                                        (state_q == ST_FILL) || (state_q == ST_PAD) ||
                                        ((state_q == ST_CODE) && bch_done));
  assign cfg_ready_o     = 1'b1;
  assign pre_sat         = (pre_q > 6'(MaxPreamble)) ? 6'(MaxPreamble) : pre_q;

  always_comb begin
    bch_req.start = in_fire && (in_cmd == CMD_START || in_cmd == CMD_MESSAGE);
    bch_req.msg   = (in_cmd == CMD_MESSAGE) ? {1'b1, in_payload}
                                            : {1'b0, in_address[20:3], in_fbits};
  end

  pcbe_bch u_bch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (bch_req),
    .done_o     (bch_done),
    .codeword_o (bch_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= 6'd18;
    end else if (cfg_valid_i) begin
      pre_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      frame_q     <= '0;
      cmd_q       <= CMD_NONE;
      code_kind_q <= KIND_ADDRESS;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_kind_q  <= KIND_IDLE;
      out_last_q  <= 1'b0;
    end else begin
      if (word_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q <= in_cmd;
            unique case (in_cmd)
              CMD_START: begin
                frame_q     <= in_address[2:0];
                code_kind_q <= KIND_ADDRESS;
                pos_q       <= {1'b0, in_address[2:0], 1'b1};
                cnt_q       <= pre_sat;
                state_q     <= (pre_sat != '0) ? ST_PRE : ST_SYNC;
              end
              CMD_MESSAGE: begin
                code_kind_q <= KIND_MESSAGE;
                if (pos_q >= 5'(BatchWords)) begin
                  pos_q   <= 5'd1;
                  state_q <= ST_SYNC;
                end else begin
                  pos_q   <= pos_q + 5'd1;
                  state_q <= ST_CODE;
                end
              end
              CMD_END: begin
                cnt_q   <= (pos_q >= 5'(BatchWords)) ? 6'd1
                                                     : 6'(BatchWords) - {1'b0, pos_q};
                pos_q   <= '0;
                state_q <= ST_PAD;
              end
              CMD_NONE: begin
                state_q <= ST_IDLE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PRE: begin
          if (can_emit) begin
            out_data_q  <= PreambleWord;
            out_kind_q  <= KIND_PREAMBLE;
            out_last_q  <= 1'b0;
            cnt_q       <= cnt_q - 6'd1;
            if (cnt_q == 6'd1) begin
              state_q <= ST_SYNC;
            end
          end
        end
        ST_SYNC: begin
          if (can_emit) begin
            out_data_q  <= SyncWord;
            out_kind_q  <= KIND_SYNC;
            out_last_q  <= 1'b0;
            cnt_q       <= {2'b0, frame_q, 1'b0};
            // start commands idle up to their frame before the address word
            if (cmd_q == CMD_START && frame_q != '0) begin
              state_q <= ST_FILL;
            end else begin
              state_q <= ST_CODE;
            end
          end
        end
        ST_FILL, ST_PAD: begin
          if (can_emit) begin
            out_data_q  <= IdleWord;
            out_kind_q  <= KIND_IDLE;
            out_last_q  <= (state_q == ST_PAD) && (cnt_q == 6'd1);
            cnt_q       <= cnt_q - 6'd1;
            if (cnt_q == 6'd1) begin
              state_q <= (state_q == ST_PAD) ? ST_IDLE : ST_CODE;
            end
          end
        end
        ST_CODE: begin
          if (can_emit && bch_done) begin
            out_data_q  <= bch_word;
            out_kind_q  <= code_kind_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
